// ===== hdl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared codes, widths and types of the stack calculator core.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  // Fixed field widths of the stream items
  localparam int unsigned OP_W        = 4;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEPTH_OUT_W = 7;
  localparam int unsigned S_TDATA_W   = 72;
  localparam int unsigned M_TDATA_W   = 48;

  // Instruction codes
  localparam logic [OP_W-1:0] OP_PUSH  = 4'd0;
  localparam logic [OP_W-1:0] OP_OUT   = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
  localparam logic [OP_W-1:0] OP_SQRT  = 4'd6;
  localparam logic [OP_W-1:0] OP_PUSHR = 4'd7;
  localparam logic [OP_W-1:0] OP_POPR  = 4'd8;
  localparam logic [OP_W-1:0] OP_IN    = 4'd9;
  localparam logic [OP_W-1:0] OP_HALT  = 4'd10;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NEGSQ   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BADREG  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd6;
  localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd7;

  // Operations of the iterative arithmetic unit
  typedef enum logic [1:0] {
    ITER_MUL  = 2'd0,
    ITER_DIV  = 2'd1,
    ITER_SQRT = 2'd2
  } iter_op_e;

  // Request to the iterative unit
  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_req_t;

endpackage

`default_nettype wire

// ===== hdl/scc_stack_mem.sv =====
// ----------------------------------------------------------------------------
// scc_stack_mem
// Stack word memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_stack_mem #(
  parameter int unsigned Depth     = 64,
  parameter int unsigned DataWidth = 32,
  localparam int unsigned AddrW    = $clog2(Depth)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrW-1:0]     waddr_i,
  input  wire logic [DataWidth-1:0] wdata_i,
  input  wire logic [AddrW-1:0]     raddr_a_i,
  input  wire logic [AddrW-1:0]     raddr_b_i,
  output logic      [DataWidth-1:0] rdata_a_o,
  output logic      [DataWidth-1:0] rdata_b_o
);

  logic [DataWidth-1:0] mem [Depth];
  logic [DataWidth-1:0] rdata_a_q;
  logic [DataWidth-1:0] rdata_b_q;

  // Write and read, data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ===== hdl/scc_iter_unit.sv =====
// ----------------------------------------------------------------------------
// scc_iter_unit
// Bit-serial multiply, truncating signed divide and floor square root.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_iter_unit #(
  parameter int unsigned DataWidth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire scc_pkg::iter_req_t       req_i,
  input  wire logic     [DataWidth-1:0] a_i,
  input  wire logic     [DataWidth-1:0] b_i,
  output logic                          done_o,
  output logic          [DataWidth-1:0] result_o
);

  localparam int unsigned W      = DataWidth;
  localparam int unsigned SqIter = (W + 1) / 2;
  localparam int unsigned SqW    = 2 * SqIter;
  localparam int unsigned CntW   = $clog2(W + 1);

  logic                busy_q;
  scc_pkg::iter_op_e   op_q;
  logic [CntW-1:0]     cnt_q;
  logic [W-1:0]        acc_q;
  logic [W-1:0]        mcand_q;
  logic [W-1:0]        mplier_q;
  logic [W:0]          rem_q;
  logic [W-1:0]        dvsr_q;
  logic                neg_q;
  logic [SqW-1:0]      sqx_q;
  logic [SqIter+1:0]   sqrem_q;
  logic [SqIter-1:0]   root_q;

  logic [W-1:0]        abs_a;
  logic [W-1:0]        abs_b;
  logic [W:0]          div_sh;
  logic                div_fit;
  logic [SqIter+1:0]   sq_sh;
  logic [SqIter+1:0]   sq_trial;
  logic                sq_fit;

  // Magnitudes for the divide
  assign abs_a = a_i[W-1] ? ({W{1'b0}} - a_i) : a_i;
  assign abs_b = b_i[W-1] ? ({W{1'b0}} - b_i) : b_i;

  // One restoring divide step and one square root digit step
  assign div_sh   = {rem_q[W-1:0], mcand_q[W-1]};
  assign div_fit  = div_sh >= {1'b0, dvsr_q};
  assign sq_sh    = {sqrem_q[SqIter-1:0], sqx_q[SqW-1:SqW-2]};
  assign sq_trial = {root_q, 2'b01};
  assign sq_fit   = sq_sh >= sq_trial;

  // Control: load on start, count steps, finish in the cycle after the last step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= scc_pkg::ITER_MUL;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      op_q   <= req_i.op;
      cnt_q  <= (req_i.op == scc_pkg::ITER_SQRT) ? CntW'(SqIter) : CntW'(W);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q   <= '0;
      rem_q   <= '0;
      sqrem_q <= '0;
      root_q  <= '0;
      sqx_q   <= SqW'(a_i);
      dvsr_q  <= abs_b;
      neg_q   <= a_i[W-1] ^ b_i[W-1];
      mplier_q <= b_i;
      mcand_q <= (req_i.op == scc_pkg::ITER_DIV) ? abs_a : a_i;
    end else if (busy_q && cnt_q != '0) begin
      case (op_q)
        scc_pkg::ITER_MUL: begin
          if (mplier_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q  <= {mcand_q[W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[W-1:1]};
        end
        scc_pkg::ITER_DIV: begin
          rem_q   <= div_fit ? (div_sh - {1'b0, dvsr_q}) : div_sh;
          acc_q   <= {acc_q[W-2:0], div_fit};
          mcand_q <= {mcand_q[W-2:0], 1'b0};
        end
        default: begin
          sqrem_q <= sq_fit ? (sq_sh - sq_trial) : sq_sh;
          root_q  <= {root_q[SqIter-2:0], sq_fit};
          sqx_q   <= {sqx_q[SqW-3:0], 2'b00};
        end
      endcase
    end
  end

  assign done_o = busy_q && (cnt_q == '0);

  // Select the finished result
  always_comb begin
    case (op_q)
      scc_pkg::ITER_MUL:  result_o = acc_q;
      scc_pkg::ITER_DIV:  result_o = neg_q ? ({W{1'b0}} - acc_q) : acc_q;
      default:            result_o = W'(root_q);
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/stack_calculator_core.sv =====
// ----------------------------------------------------------------------------
// stack_calculator_core
// Stack-machine integer calculator, one instruction per input item.
// ----------------------------------------------------------------------------
// Usage: each item on the s_axis channel carries one instruction (tdata) and
// the end-of-program mark (tlast). Each item produces exactly one result item
// on the m_axis channel: popped word, status, stack depth and halt flag in
// tdata, and the popped-word flag in tuser.
// Push, out, add, sub, pushr, popr, in, halt and every failing instruction go
// from the decode state straight to the commit state; mul, div and sqrt first
// run in a shared bit-serial unit between decode and commit. The stack memory
// read is registered ahead of the decode. One item is in flight at a time:
// s_axis_tready is high once the previous item has committed, even while its
// result waits.
// Reset empties the stack, clears the register file and the halt flag; stack
// words are never used before being written. When the receiver stalls, the
// result waits in the output register and the next item waits before commit.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_calculator_core #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned NUM_REGS    = 4,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // operation[3:0], operand[35:4], keyboard_value[67:36], zero pad[71:68]
  input  wire logic [scc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                            s_axis_tlast,   // end_of_program
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // out_value[31:0], status[34:32], stack_depth[41:35], halted[42], zero[47:43]
  output logic      [scc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                                 m_axis_tuser,   // out_valid
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned PW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned FW   = scc_pkg::FIELD_W;
  localparam int unsigned STW  = scc_pkg::STATUS_W;
  localparam int unsigned PADW = scc_pkg::M_TDATA_W - FW - STW - scc_pkg::DEPTH_OUT_W - 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ITER = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // Control state
  logic [1:0]            state_q, state_d;
  logic [PW-1:0]         sp_q;
  logic                  halt_q;
  logic [W-1:0]          regs_q [NUM_REGS];
  logic                  m_valid_q;

  // Item and pending commit
  logic [scc_pkg::OP_W-1:0] op_q;
  logic signed [FW-1:0]  operand_q;
  logic signed [FW-1:0]  kbd_q;
  logic                  eop_q;
  logic [STW-1:0]        st_q, st_d;
  logic [FW-1:0]         oval_q, oval_d;
  logic                  ovalid_q, ovalid_d;
  logic                  mwe_q, mwe_d;
  logic [AW-1:0]         maddr_q, maddr_d;
  logic [W-1:0]          wdata_q, wdata_d;
  logic [PW-1:0]         spn_q, spn_d;
  logic                  rwe_q, rwe_d;
  logic                  halt_n_q, halt_d;
  logic [scc_pkg::M_TDATA_W-1:0] m_data_q;
  logic                  m_user_q;

  logic                  s_fire;
  logic                  out_free;
  logic                  commit;
  logic [W-1:0]          top;
  logic [W-1:0]          sec;
  logic                  ge1, ge2, full;
  logic                  reg_ok;
  logic [RW-1:0]         ridx;
  logic                  push_en;
  logic [W-1:0]          push_val;
  scc_pkg::iter_req_t    iter_req;
  logic                  iter_done;
  logic [W-1:0]          iter_res;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign commit        = (state_q == S_DONE) && out_free;

  // Stack memory, read at top and second from the current pointer
  scc_stack_mem #(
    .Depth     (STACK_DEPTH),
    .DataWidth (W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (commit && mwe_q),
    .waddr_i   (maddr_q),
    .wdata_i   (wdata_q),
    .raddr_a_i (AW'(sp_q - PW'(1))),
    .raddr_b_i (AW'(sp_q - PW'(2))),
    .rdata_a_o (top),
    .rdata_b_o (sec)
  );

  scc_iter_unit #(
    .DataWidth (W)
  ) u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (iter_req),
    .a_i      ((op_q == scc_pkg::OP_SQRT) ? top : sec),
    .b_i      (top),
    .done_o   (iter_done),
    .result_o (iter_res)
  );

  assign ge1    = (sp_q != '0);
  assign ge2    = (sp_q >= PW'(2));
  assign full   = (sp_q == PW'(STACK_DEPTH));
  assign reg_ok = !operand_q[FW-1] && (operand_q[FW-2:0] < (FW-1)'(NUM_REGS));
  assign ridx   = operand_q[RW-1:0];

  // Decode the held item against the stack words just read
  always_comb begin
    st_d      = scc_pkg::ST_OK;
    oval_d    = '0;
    ovalid_d  = 1'b0;
    mwe_d     = 1'b0;
    maddr_d   = AW'(sp_q);
    wdata_d   = '0;
    spn_d     = sp_q;
    rwe_d     = 1'b0;
    halt_d    = halt_q || eop_q;
    push_en   = 1'b0;
    push_val  = '0;
    iter_req.start = 1'b0;
    iter_req.op    = scc_pkg::ITER_MUL;
    if (halt_q) begin
      st_d = scc_pkg::ST_HALTED;
    end else begin
      case (op_q)
        scc_pkg::OP_PUSH: begin
          push_en  = 1'b1;
          push_val = W'(operand_q);
        end
        scc_pkg::OP_OUT: begin
          if (!ge1) begin
            st_d = scc_pkg::ST_UNDER;
          end else begin
            spn_d    = sp_q - PW'(1);
            oval_d   = FW'($signed(top));
            ovalid_d = 1'b1;
          end
        end
        scc_pkg::OP_ADD, scc_pkg::OP_SUB: begin
          if (!ge2) begin
            st_d = scc_pkg::ST_UNDER;
          end else begin
            mwe_d   = 1'b1;
            maddr_d = AW'(sp_q - PW'(2));
            wdata_d = (op_q == scc_pkg::OP_ADD) ? (sec + top) : (sec - top);
            spn_d   = sp_q - PW'(1);
          end
        end
        scc_pkg::OP_MUL, scc_pkg::OP_DIV: begin
          if (!ge2) begin
            st_d = scc_pkg::ST_UNDER;
          end else if (op_q == scc_pkg::OP_DIV && top == '0) begin
            st_d = scc_pkg::ST_DIVZ;
          end else begin
            iter_req.start = 1'b1;
            iter_req.op    = (op_q == scc_pkg::OP_MUL) ? scc_pkg::ITER_MUL
                                                       : scc_pkg::ITER_DIV;
            mwe_d   = 1'b1;
            maddr_d = AW'(sp_q - PW'(2));
            spn_d   = sp_q - PW'(1);
          end
        end
        scc_pkg::OP_SQRT: begin
          if (!ge1) begin
            st_d = scc_pkg::ST_UNDER;
          end else if (top[W-1]) begin
            st_d = scc_pkg::ST_NEGSQ;
          end else begin
            iter_req.start = 1'b1;
            iter_req.op    = scc_pkg::ITER_SQRT;
            mwe_d   = 1'b1;
            maddr_d = AW'(sp_q - PW'(1));
          end
        end
        scc_pkg::OP_PUSHR: begin
          if (!reg_ok) begin
            st_d = scc_pkg::ST_BADREG;
          end else begin
            push_en  = 1'b1;
            push_val = regs_q[ridx];
          end
        end
        scc_pkg::OP_POPR: begin
          if (!reg_ok) begin
            st_d = scc_pkg::ST_BADREG;
          end else if (!ge1) begin
            st_d = scc_pkg::ST_UNDER;
          end else begin
            rwe_d   = 1'b1;
            wdata_d = top;
            spn_d   = sp_q - PW'(1);
          end
        end
        scc_pkg::OP_IN: begin
          push_en  = 1'b1;
          push_val = W'(kbd_q);
        end
        scc_pkg::OP_HALT: begin
          halt_d = 1'b1;
        end
        default: begin
          st_d = scc_pkg::ST_UNKNOWN;
        end
      endcase
      // Common push path
      if (push_en) begin
        if (full) begin
          st_d = scc_pkg::ST_OVER;
        end else begin
          mwe_d   = 1'b1;
          maddr_d = AW'(sp_q);
          wdata_d = push_val;
          spn_d   = sp_q + PW'(1);
        end
      end
    end
    // Gate the iterative unit to the decode cycle
    if (state_q != S_EXEC) begin
      iter_req.start = 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_fire) state_d = S_EXEC;
      S_EXEC: state_d = iter_req.start ? S_ITER : S_DONE;
      S_ITER: if (iter_done) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers: commit pointer, halt flag, register file, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sp_q      <= '0;
      halt_q    <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        sp_q      <= spn_q;
        halt_q    <= halt_n_q;
        m_valid_q <= 1'b1;
        if (rwe_q) begin
          regs_q[ridx] <= wdata_q;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the item, the decoded commit and the result
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q      <= s_axis_tdata[scc_pkg::OP_W-1:0];
      operand_q <= s_axis_tdata[scc_pkg::OP_W +: FW];
      kbd_q     <= s_axis_tdata[scc_pkg::OP_W + FW +: FW];
      eop_q     <= s_axis_tlast;
    end
    if (state_q == S_EXEC) begin
      st_q     <= st_d;
      oval_q   <= oval_d;
      ovalid_q <= ovalid_d;
      mwe_q    <= mwe_d;
      maddr_q  <= maddr_d;
      wdata_q  <= wdata_d;
      spn_q    <= spn_d;
      rwe_q    <= rwe_d;
      halt_n_q <= halt_d;
    end
    if (state_q == S_ITER && iter_done) begin
      wdata_q <= iter_res;
    end
    if (commit) begin
      m_data_q <= {{PADW{1'b0}}, halt_n_q, scc_pkg::DEPTH_OUT_W'(spn_q), st_q, oval_q};
      m_user_q <= ovalid_q;
    end
  end

  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tvalid = m_valid_q;

endmodule

`default_nettype wire

// ===== test/stack_calculator_core_tb.sv =====
// ----------------------------------------------------------------------------
// stack_calculator_core_tb
// Self-checking testbench for the stack calculator core.
// ----------------------------------------------------------------------------
// A queue of instructions feeds a stream driver; a clocked predictor runs each
// accepted instruction against its own copy of the stack, register file and
// halt flag and queues the expected result. The monitor compares each result
// item field by field with the oldest expected one. The program opens with
// directed corner cases (underflow, bad register, unknown opcodes, wrap,
// divide overflow, divide by zero, negative root), then runs random
// expressions, register moves, stack fill and drain bursts and noise, and
// ends with a halt followed by items that must all report halted. Both sides
// idle at random, except in one quiet stretch.
// ----------------------------------------------------------------------------

module stack_calculator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned NUM_REGS    = 4;
  localparam int unsigned DRAIN_WAIT  = 60;   // longest latency plus margin
  localparam logic [31:0] WORD_MIN    = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_NEG1   = 32'hFFFF_FFFF;
  localparam logic [scc_pkg::OP_W-1:0] OP_BAD_LO = 4'd11;
  localparam logic [scc_pkg::OP_W-1:0] OP_BAD_HI = 4'd15;

  typedef struct {
    logic [scc_pkg::OP_W-1:0] op;
    logic [31:0]     operand;
    logic [31:0]     kbd;
    logic            eop;
    bit              drain;   // hold off until every result is back
  } instr_t;

  typedef struct {
    logic [31:0]                      value;
    logic                             valid;
    logic [scc_pkg::STATUS_W-1:0]     status;
    logic [scc_pkg::DEPTH_OUT_W-1:0]  depth;
    logic                             halted;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic [scc_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [scc_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;

  // Shadow machine state
  logic [31:0] shadow_stack [STACK_DEPTH];
  logic [31:0] calc_regs  [NUM_REGS] = '{default: '0};
  int unsigned calc_sp   = 0;
  bit          calc_halt = 1'b0;

  instr_t  program_q [$];
  result_t due_results [$];
  instr_t  in_flight;
  result_t want;
  int      sent_cnt = 0;
  int      done_cnt = 0;
  int      fail_cnt = 0;

  logic [scc_pkg::OP_W-1:0] arith_ops [4] = '{scc_pkg::OP_ADD, scc_pkg::OP_SUB,
                                              scc_pkg::OP_MUL, scc_pkg::OP_DIV};

  stack_calculator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #4 clk_i = ~clk_i;

  // Floor square root, one result bit per pass
  function automatic logic [31:0] floor_sqrt(logic [31:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= 64'(x)) root = trial;
    end
    return root;
  endfunction

  function automatic logic [scc_pkg::STATUS_W-1:0] push_word(logic [31:0] w);
    if (calc_sp >= STACK_DEPTH) return scc_pkg::ST_OVER;
    shadow_stack[calc_sp] = w;
    calc_sp++;
    return scc_pkg::ST_OK;
  endfunction

  // Run one instruction on the shadow state and form its result item
  function automatic result_t execute_instr(instr_t it);
    result_t     r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] w;
    r = '{value: '0, valid: 1'b0, status: scc_pkg::ST_OK, depth: '0, halted: 1'b0};
    w = '0;
    if (calc_halt) begin
      r.status = scc_pkg::ST_HALTED;
    end else begin
      case (it.op)
        scc_pkg::OP_PUSH: r.status = push_word(it.operand);
        scc_pkg::OP_OUT: begin
          if (calc_sp < 1) begin
            r.status = scc_pkg::ST_UNDER;
          end else begin
            calc_sp--;
            r.value = shadow_stack[calc_sp];
            r.valid = 1'b1;
          end
        end
        scc_pkg::OP_ADD, scc_pkg::OP_SUB, scc_pkg::OP_MUL, scc_pkg::OP_DIV: begin
          if (calc_sp < 2) begin
            r.status = scc_pkg::ST_UNDER;
          end else begin
            b = shadow_stack[calc_sp-1];
            a = shadow_stack[calc_sp-2];
            case (it.op)
              scc_pkg::OP_ADD: w = a + b;
              scc_pkg::OP_SUB: w = a - b;
              scc_pkg::OP_MUL: w = a * b;
              default: begin
                // divide by minus one wraps, so negate instead
                if (b == '0) r.status = scc_pkg::ST_DIVZ;
                else if (b == WORD_NEG1) w = '0 - a;
                else w = $signed(a) / $signed(b);
              end
            endcase
            if (r.status == scc_pkg::ST_OK) begin
              shadow_stack[calc_sp-2] = w;
              calc_sp--;
            end
          end
        end
        scc_pkg::OP_SQRT: begin
          if (calc_sp < 1) r.status = scc_pkg::ST_UNDER;
          else if (shadow_stack[calc_sp-1][31]) r.status = scc_pkg::ST_NEGSQ;
          else shadow_stack[calc_sp-1] = floor_sqrt(shadow_stack[calc_sp-1]);
        end
        scc_pkg::OP_PUSHR: begin
          if (it.operand >= NUM_REGS) r.status = scc_pkg::ST_BADREG;
          else r.status = push_word(calc_regs[it.operand]);
        end
        scc_pkg::OP_POPR: begin
          // register index is checked ahead of underflow
          if (it.operand >= NUM_REGS) begin
            r.status = scc_pkg::ST_BADREG;
          end else if (calc_sp < 1) begin
            r.status = scc_pkg::ST_UNDER;
          end else begin
            calc_sp--;
            calc_regs[it.operand] = shadow_stack[calc_sp];
          end
        end
        scc_pkg::OP_IN:   r.status = push_word(it.kbd);
        scc_pkg::OP_HALT: calc_halt = 1'b1;
        default: r.status = scc_pkg::ST_UNKNOWN;
      endcase
      if (it.eop) calc_halt = 1'b1;
    end
    r.depth  = scc_pkg::DEPTH_OUT_W'(calc_sp);
    r.halted = calc_halt;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'd1;
      2: return WORD_NEG1;
      3: return WORD_MIN;
      4: return WORD_MAX;
      5: return 32'($signed($urandom_range(200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_instr(logic [scc_pkg::OP_W-1:0] op, logic [31:0] operand,
                           logic [31:0] kbd, logic eop = 1'b0, bit drain = 1'b0);
    program_q.push_back('{op: op, operand: operand, kbd: kbd, eop: eop, drain: drain});
  endtask

  // Push a random word by immediate or by keyboard value
  task automatic push_value(bit drain = 1'b0);
    if ($urandom_range(1)) add_instr(scc_pkg::OP_PUSH, rand_word(), $urandom, 1'b0, drain);
    else add_instr(scc_pkg::OP_IN, $urandom, rand_word(), 1'b0, drain);
  endtask

  // Present items; predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(execute_instr(in_flight));
        sent_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (program_q.size() != 0 &&
            !(program_q[0].drain && due_results.size() != 0) &&
            !((sent_cnt < 200 || sent_cnt >= 320) && $urandom_range(99) < 37)) begin
          in_flight = program_q.pop_front();
          s_axis_tdata  <= {4'b0, in_flight.kbd, in_flight.operand, in_flight.op};
          s_axis_tlast  <= in_flight.eop;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: result %0d %s mismatch, expected %0h, actual %0h",
               $time, done_cnt, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Accept results and check them against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: unexpected result item, expected none, actual %0h",
                   $time, m_axis_tdata);
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          compare_field("out_value", want.value, m_axis_tdata[31:0]);
          compare_field("out_valid", 32'(want.valid), 32'(m_axis_tuser));
          compare_field("status", 32'(want.status), 32'(m_axis_tdata[34:32]));
          compare_field("stack_depth", 32'(want.depth), 32'(m_axis_tdata[41:35]));
          compare_field("halted", 32'(want.halted), 32'(m_axis_tdata[42]));
        end
        done_cnt++;
      end
      m_axis_tready <= (done_cnt >= 200 && done_cnt < 320) || ($urandom_range(99) >= 37);
    end
  end

  // Build the program, release reset and wait for the last result
  initial begin
    int  pick;
    int  reg_sel;
    bit  filled;
    filled = 1'b0;

    // Corner cases on an empty stack and bad codes
    add_instr(scc_pkg::OP_OUT, $urandom, $urandom);
    add_instr(scc_pkg::OP_ADD, $urandom, $urandom);
    add_instr(scc_pkg::OP_SQRT, $urandom, $urandom);
    add_instr(scc_pkg::OP_POPR, 32'd4, $urandom);
    add_instr(scc_pkg::OP_POPR, 32'd0, $urandom);
    add_instr(scc_pkg::OP_PUSHR, WORD_MIN, $urandom);
    add_instr(OP_BAD_LO, $urandom, $urandom);
    add_instr(OP_BAD_HI, $urandom, $urandom);
    // Wrap, divide overflow, divide by zero, roots and register moves
    add_instr(scc_pkg::OP_PUSH, WORD_MAX, $urandom);
    add_instr(scc_pkg::OP_PUSH, 32'd1, $urandom);
    add_instr(scc_pkg::OP_ADD, $urandom, $urandom);
    add_instr(scc_pkg::OP_PUSH, WORD_NEG1, $urandom);
    add_instr(scc_pkg::OP_DIV, $urandom, $urandom);
    add_instr(scc_pkg::OP_PUSH, 32'd0, $urandom);
    add_instr(scc_pkg::OP_DIV, $urandom, $urandom);
    add_instr(scc_pkg::OP_MUL, $urandom, $urandom);
    add_instr(scc_pkg::OP_SQRT, $urandom, $urandom);
    add_instr(scc_pkg::OP_IN, $urandom, 32'hFFFF_FFF9);
    add_instr(scc_pkg::OP_SQRT, $urandom, $urandom);
    add_instr(scc_pkg::OP_SUB, $urandom, $urandom);
    add_instr(scc_pkg::OP_IN, $urandom, WORD_MAX);
    add_instr(scc_pkg::OP_SQRT, $urandom, $urandom);
    add_instr(scc_pkg::OP_POPR, 32'd3, $urandom);
    add_instr(scc_pkg::OP_PUSHR, 32'd3, $urandom);
    add_instr(scc_pkg::OP_MUL, $urandom, $urandom);
    add_instr(scc_pkg::OP_OUT, $urandom, $urandom, 1'b0, 1'b1);

    // Random program: mostly well-formed fragments, some noise
    while (program_q.size() < 26 + 410) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_value();
        push_value();
        add_instr(arith_ops[$urandom_range(3)], $urandom, $urandom);
        if ($urandom_range(9) < 6) add_instr(scc_pkg::OP_OUT, $urandom, $urandom);
      end else if (pick < 55) begin
        push_value();
        add_instr(scc_pkg::OP_SQRT, $urandom, $urandom);
        if ($urandom_range(9) < 7) add_instr(scc_pkg::OP_OUT, $urandom, $urandom);
      end else if (pick < 70) begin
        reg_sel = ($urandom_range(9) == 0) ? int'(rand_word()) : int'($urandom_range(3));
        push_value();
        add_instr(scc_pkg::OP_POPR, 32'(reg_sel), $urandom);
        add_instr(scc_pkg::OP_PUSHR, 32'(reg_sel), $urandom);
        add_instr(scc_pkg::OP_OUT, $urandom, $urandom);
      end else if (pick < 96) begin
        add_instr(scc_pkg::OP_W'($urandom_range(15)),
                  ($urandom_range(3) == 0) ? 32'($urandom_range(5)) : rand_word(),
                  rand_word());
      end else if (!filled) begin
        // overfill the stack, then try every kind of push on it
        push_value(1'b1);
        repeat (STACK_DEPTH + 2) push_value();
        add_instr(scc_pkg::OP_PUSHR, 32'($urandom_range(3)), $urandom);
        add_instr(scc_pkg::OP_IN, $urandom, rand_word());
        filled = 1'b1;
      end else begin
        // empty the stack and run past the bottom
        repeat (STACK_DEPTH + 4) add_instr(scc_pkg::OP_OUT, $urandom, $urandom);
        filled = 1'b0;
      end
    end

    // Halt at the end mark, then items that must report halted
    add_instr(scc_pkg::OP_HALT, $urandom, $urandom, 1'b1, 1'b1);
    repeat (6) add_instr(scc_pkg::OP_W'($urandom_range(15)), rand_word(), rand_word(),
                         1'($urandom_range(1)));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (program_q.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("stack_calculator_core test passed");
    end else begin
      $display("stack_calculator_core test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(2_000_000);
    $display("stack_calculator_core test failed");
    $finish;
  end

endmodule
